// ===== rtl/ddwn_pkg.sv =====
package ddwn_pkg;

  // field widths
  localparam int CMD_W      = 3;
  localparam int POS_W      = 16;
  localparam int ANG_W      = 16;
  localparam int SPD_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Q3.13 angle constants
  localparam int ANG_PI     = 25736;
  localparam int ANG_TWO_PI = 51472;

  localparam int CORDIC_STEPS_DEF = 14;
  localparam int CORDIC_W         = 28;  // 17-bit error x 256 plus CORDIC gain
  localparam int Z_W              = 18;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_MOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TURN = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GO   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_STOP = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_SPEED   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROTATE_SPEED  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRIVE_THRESH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_THRESH   = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_DONE = 2'd0,
    MODE_MOVE = 2'd1,
    MODE_GO   = 2'd2,
    MODE_ROT  = 2'd3
  } mode_t;

  // atan(2^-i) in Q3.13
  function automatic logic [12:0] atan_q13(input logic [3:0] i);
    logic [12:0] a;
    case (i)
      4'd0:    a = 13'd6434;
      4'd1:    a = 13'd3798;
      4'd2:    a = 13'd2007;
      4'd3:    a = 13'd1019;
      4'd4:    a = 13'd511;
      4'd5:    a = 13'd256;
      4'd6:    a = 13'd128;
      4'd7:    a = 13'd64;
      4'd8:    a = 13'd32;
      4'd9:    a = 13'd16;
      4'd10:   a = 13'd8;
      4'd11:   a = 13'd4;
      4'd12:   a = 13'd2;
      4'd13:   a = 13'd1;
      default: a = 13'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/ddwn_if.sv =====
interface ddwn_in_if;
  import ddwn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         cmd;
  logic signed [POS_W-1:0]  pose_x;
  logic signed [POS_W-1:0]  pose_y;
  logic signed [ANG_W-1:0]  pose_heading;
  logic signed [POS_W-1:0]  goal_x;
  logic signed [POS_W-1:0]  goal_y;
  logic signed [ANG_W-1:0]  goal_heading;

  modport source (
    output valid, cmd, pose_x, pose_y, pose_heading, goal_x, goal_y, goal_heading,
    input  ready
  );
  modport sink (
    input  valid, cmd, pose_x, pose_y, pose_heading, goal_x, goal_y, goal_heading,
    output ready
  );
endinterface

interface ddwn_out_if;
  import ddwn_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SPD_W-1:0]  left_speed;
  logic signed [SPD_W-1:0]  right_speed;
  logic [MODE_W-1:0]        mode_now;

  modport source (
    output valid, left_speed, right_speed, mode_now,
    input  ready
  );
  modport sink (
    input  valid, left_speed, right_speed, mode_now,
    output ready
  );
endinterface

// ===== rtl/diff_drive_waypoint_navigator_top.sv =====
// Differential-drive waypoint navigator.
// in_ch carries one transaction per command or pose tick (valid/ready); every
// accepted transaction yields exactly one transaction on out_ch with the
// wheel speeds held after it and the mode it leaves behind.
// cfg_we/cfg_index/cfg_data write the five speed, gain and threshold
// registers; write them only while the block is idle.
// Path through the sequencer: commands and done-mode ticks go EVAL, OUT;
// a move-to tick that arrives EVAL, DIST, OUT; a rotate tick EVAL, ERR,
// MUL, OUT; a go tick EVAL, ERR, MUL, SPEED, OUT; a move-to tick with a zero
// error vector EVAL, DIST, ERR, MUL, SPEED, OUT; one that runs the CORDIC
// EVAL, DIST, CORDIC, CLAMP, ERR, MUL, SPEED, OUT. The single shared CORDIC
// add/shift datapath does one micro-rotation per cycle, followed by one
// multiplier pass. One transaction is worked at a time: in_ch.ready is high
// only while the sequencer is idle.
// The result sits in an output register; a new transaction may be accepted
// while it waits, and the next result is held back until out_ch.ready.
// Reset (rst_n low, synchronous) clears the registers, the mode (done), the
// destination, target heading and held speeds, and drops out_ch.valid.
module diff_drive_waypoint_navigator_top #(
  parameter int CORDIC_STEPS = ddwn_pkg::CORDIC_STEPS_DEF  // 8..16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  ddwn_in_if.sink                             in_ch,
  ddwn_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [ddwn_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ddwn_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import ddwn_pkg::*;

  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int PROD_W  = 35;          // 17-bit gain x 18-bit error
  localparam int SHIFT_Q = 21;

  localparam logic signed [16:0] PI17     = 17'(ANG_PI);
  localparam logic signed [16:0] NPI17    = -17'(ANG_PI);
  localparam logic signed [16:0] TWOPI17  = 17'(ANG_TWO_PI);
  localparam logic signed [17:0] PI18     = 18'(ANG_PI);
  localparam logic signed [17:0] NPI18    = -18'(ANG_PI);
  localparam logic signed [17:0] TWOPI18  = 18'(ANG_TWO_PI);
  localparam logic signed [Z_W-1:0] PIZ   = Z_W'(ANG_PI);
  localparam logic signed [Z_W-1:0] NPIZ  = -Z_W'(ANG_PI);
  localparam logic signed [PROD_W-1:0] HALF_P = PROD_W'(1) <<< (SHIFT_Q - 1);
  localparam logic signed [PROD_W-1:0] RND_P  = (PROD_W'(1) <<< SHIFT_Q) - PROD_W'(1);

  // sequencer, one-hot
  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_EVAL   = 9'b000000010,
    S_DIST   = 9'b000000100,
    S_CORDIC = 9'b000001000,
    S_CLAMP  = 9'b000010000,
    S_ERR    = 9'b000100000,
    S_MUL    = 9'b001000000,
    S_SPEED  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  function automatic logic signed [SPD_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [SPD_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = v[SPD_W-1:0];
    end
    return r;
  endfunction

  // control and architectural state
  state_t                    state_r, state_nxt;
  mode_t                     mode_r, mode_nxt;
  logic signed [POS_W-1:0]   dest_x_r, dest_x_nxt, dest_y_r, dest_y_nxt;
  logic signed [ANG_W-1:0]   target_r, target_nxt;
  logic signed [SPD_W-1:0]   left_r, left_nxt, right_r, right_nxt;
  logic [14:0]               drive_speed_r, rotate_speed_r, head_thresh_r;
  logic [15:0]               steer_gain_r, arrive_thresh_r;
  logic                      out_valid_r, out_valid_nxt;

  // latched transaction
  logic [CMD_W-1:0]          cmd_r, cmd_nxt;
  logic signed [POS_W-1:0]   px_r, px_nxt, py_r, py_nxt, gx_r, gx_nxt, gy_r, gy_nxt;
  logic signed [ANG_W-1:0]   ph_r, ph_nxt, gh_r, gh_nxt;

  // datapath
  logic signed [16:0]        ex_r, ex_nxt, ey_r, ey_nxt;
  logic signed [CORDIC_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [Z_W-1:0]     cz_r, cz_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic signed [17:0]        err_r, err_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;

  logic signed [SPD_W-1:0]   out_left_r, out_left_nxt, out_right_r, out_right_nxt;
  logic [MODE_W-1:0]         out_mode_r, out_mode_nxt;

  // combinational temporaries
  logic signed [16:0]        gh_ext, gh_norm;
  logic [16:0]               abs_ex, abs_ey, abs_err;
  logic [17:0]               l1;
  logic signed [CORDIC_W-1:0] sx, sy, dx, dy;
  logic signed [Z_W-1:0]     ang;
  logic signed [17:0]        e_raw;
  logic signed [PROD_W-1:0]  rnd, quo;
  logic signed [17:0]        diff, drive_ext;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.left_speed  = out_left_r;
  assign out_ch.right_speed = out_right_r;
  assign out_ch.mode_now    = out_mode_r;

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    dest_x_nxt    = dest_x_r;
    dest_y_nxt    = dest_y_r;
    target_nxt    = target_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_nxt       = cmd_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ph_nxt        = ph_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    gh_nxt        = gh_r;
    ex_nxt        = ex_r;
    ey_nxt        = ey_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    cz_nxt        = cz_r;
    step_nxt      = step_r;
    err_nxt       = err_r;
    prod_nxt      = prod_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_mode_nxt  = out_mode_r;

    // goal heading folded once into +-pi
    gh_ext = {gh_r[ANG_W-1], gh_r};
    if (gh_ext < NPI17) begin
      gh_norm = gh_ext + TWOPI17;
    end else if (gh_ext > PI17) begin
      gh_norm = gh_ext - TWOPI17;
    end else begin
      gh_norm = gh_ext;
    end

    abs_ex  = ex_r[16] ? 17'(-ex_r) : 17'(ex_r);
    abs_ey  = ey_r[16] ? 17'(-ey_r) : 17'(ey_r);
    l1      = {1'b0, abs_ex} + {1'b0, abs_ey};
    abs_err = err_r[17] ? 17'(-err_r) : 17'(err_r);

    // shared CORDIC micro-rotation unit
    sx  = CORDIC_W'(ex_r) <<< 8;
    sy  = CORDIC_W'(ey_r) <<< 8;
    dx  = cy_r >>> step_r;
    dy  = cx_r >>> step_r;
    ang = Z_W'(atan_q13(4'(step_r)));

    e_raw = {{2{target_r[ANG_W-1]}}, target_r} - {{2{ph_r[ANG_W-1]}}, ph_r};

    // gain * error + 0.5, truncated toward zero
    rnd       = prod_r + HALF_P;
    quo       = rnd[PROD_W-1] ? ((rnd + RND_P) >>> SHIFT_Q) : (rnd >>> SHIFT_Q);
    diff      = quo[17:0];
    drive_ext = {3'b000, drive_speed_r};

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          px_nxt    = in_ch.pose_x;
          py_nxt    = in_ch.pose_y;
          ph_nxt    = in_ch.pose_heading;
          gx_nxt    = in_ch.goal_x;
          gy_nxt    = in_ch.goal_y;
          gh_nxt    = in_ch.goal_heading;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_OUT;
        case (cmd_r)
          CMD_TICK: begin
            case (mode_r)
              MODE_MOVE: begin
                ex_nxt    = {dest_x_r[POS_W-1], dest_x_r} - {px_r[POS_W-1], px_r};
                ey_nxt    = {dest_y_r[POS_W-1], dest_y_r} - {py_r[POS_W-1], py_r};
                state_nxt = S_DIST;
              end
              MODE_GO, MODE_ROT: begin
                state_nxt = S_ERR;
              end
              default: begin
                state_nxt = S_OUT;
              end
            endcase
          end
          CMD_MOVE: begin
            dest_x_nxt = gx_r;
            dest_y_nxt = gy_r;
            mode_nxt   = MODE_MOVE;
          end
          CMD_TURN: begin
            target_nxt = gh_norm[ANG_W-1:0];
            mode_nxt   = MODE_ROT;
          end
          CMD_GO: begin
            target_nxt = gh_norm[ANG_W-1:0];
            mode_nxt   = MODE_GO;
          end
          CMD_STOP: begin
            left_nxt  = '0;
            right_nxt = '0;
            mode_nxt  = MODE_DONE;
          end
          default: begin
            // unused codes leave everything as it is
          end
        endcase
      end
      S_DIST: begin
        if (l1 < {2'b00, arrive_thresh_r}) begin
          left_nxt  = '0;
          right_nxt = '0;
          mode_nxt  = MODE_DONE;
          state_nxt = S_OUT;
        end else if (ex_r == '0 && ey_r == '0) begin
          target_nxt = '0;
          state_nxt  = S_ERR;
        end else begin
          // left half-plane: reflect through the origin, start at +-pi
          if (ex_r[16]) begin
            cx_nxt = -sx;
            cy_nxt = -sy;
            cz_nxt = ey_r[16] ? NPIZ : PIZ;
          end else begin
            cx_nxt = sx;
            cy_nxt = sy;
            cz_nxt = '0;
          end
          step_nxt  = '0;
          state_nxt = S_CORDIC;
        end
      end
      S_CORDIC: begin
        if (cy_r > 0) begin
          cx_nxt = cx_r + dx;
          cy_nxt = cy_r - dy;
          cz_nxt = cz_r + ang;
        end else begin
          cx_nxt = cx_r - dx;
          cy_nxt = cy_r + dy;
          cz_nxt = cz_r - ang;
        end
        if (step_r == STEP_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_CLAMP;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_CLAMP: begin
        if (cz_r > PIZ) begin
          target_nxt = ANG_W'(ANG_PI);
        end else if (cz_r < NPIZ) begin
          target_nxt = -ANG_W'(ANG_PI);
        end else begin
          target_nxt = cz_r[ANG_W-1:0];
        end
        state_nxt = S_ERR;
      end
      S_ERR: begin
        if (e_raw > PI18) begin
          err_nxt = e_raw - TWOPI18;
        end else if (e_raw < NPI18) begin
          err_nxt = e_raw + TWOPI18;
        end else begin
          err_nxt = e_raw;
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (mode_r == MODE_ROT) begin
          state_nxt = S_OUT;
          if (abs_err < {2'b00, head_thresh_r}) begin
            left_nxt  = '0;
            right_nxt = '0;
            mode_nxt  = MODE_DONE;
          end else if (err_r > 0) begin
            left_nxt  = -{1'b0, rotate_speed_r};
            right_nxt = {1'b0, rotate_speed_r};
          end else begin
            left_nxt  = {1'b0, rotate_speed_r};
            right_nxt = -{1'b0, rotate_speed_r};
          end
        end else begin
          prod_nxt  = PROD_W'($signed({1'b0, steer_gain_r}) * err_r);
          state_nxt = S_SPEED;
        end
      end
      S_SPEED: begin
        left_nxt  = sat16(drive_ext - diff);
        right_nxt = sat16(drive_ext + diff);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ch.ready) begin
          out_left_nxt  = left_r;
          out_right_nxt = right_r;
          out_mode_nxt  = mode_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      mode_r          <= MODE_DONE;
      dest_x_r        <= '0;
      dest_y_r        <= '0;
      target_r        <= '0;
      left_r          <= '0;
      right_r         <= '0;
      out_valid_r     <= 1'b0;
      drive_speed_r   <= '0;
      rotate_speed_r  <= '0;
      steer_gain_r    <= '0;
      arrive_thresh_r <= '0;
      head_thresh_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      dest_x_r    <= dest_x_nxt;
      dest_y_r    <= dest_y_nxt;
      target_r    <= target_nxt;
      left_r      <= left_nxt;
      right_r     <= right_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DRIVE_SPEED:   drive_speed_r   <= cfg_data[14:0];
          CFG_ROTATE_SPEED:  rotate_speed_r  <= cfg_data[14:0];
          CFG_STEER_GAIN:    steer_gain_r    <= cfg_data;
          CFG_ARRIVE_THRESH: arrive_thresh_r <= cfg_data;
          CFG_HEAD_THRESH:   head_thresh_r   <= cfg_data[14:0];
          default: begin
          end
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    px_r        <= px_nxt;
    py_r        <= py_nxt;
    ph_r        <= ph_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    gh_r        <= gh_nxt;
    ex_r        <= ex_nxt;
    ey_r        <= ey_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    step_r      <= step_nxt;
    err_r       <= err_nxt;
    prod_r      <= prod_nxt;
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_mode_r  <= out_mode_nxt;
  end

endmodule

// ===== bench/tb_diff_drive_waypoint_navigator_top.sv =====
`timescale 1ns / 100ps

module tb_diff_drive_waypoint_navigator_top;
  import ddwn_pkg::*;

  // One command or pose tick, as offered on in_ch
  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic signed [ANG_W-1:0] pose_heading;
    logic signed [POS_W-1:0] goal_x;
    logic signed [POS_W-1:0] goal_y;
    logic signed [ANG_W-1:0] goal_heading;
  } nav_item_t;

  // Wheel command expected back on out_ch for each accepted transaction
  typedef struct {
    logic signed [SPD_W-1:0] left;
    logic signed [SPD_W-1:0] right;
    mode_t                   mode;
  } wheel_cmd_t;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no transaction on either side
  localparam int LONG_HOLD      = 400;   // receiver hold-off used to back the block up
  localparam int SETTLE_CYCLES  = 40;    // beyond the slowest move-to tick, the one that runs the CORDIC

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  ddwn_in_if  in_ch ();
  ddwn_out_if out_ch ();

  diff_drive_waypoint_navigator_top #(
    .CORDIC_STEPS(CORDIC_STEPS_DEF)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the navigator: registers and controller state
  // ---------------------------------------------------------------------------
  logic [14:0] drive_speed;
  logic [14:0] rotate_speed;
  logic [15:0] steer_gain;
  logic [15:0] arrive_thresh;
  logic [14:0] head_thresh;

  mode_t nav_mode;
  int    dest_x, dest_y, tgt_heading;
  int    left_held, right_held;

  // atan(2^-i), Q3.13
  int atan_lut [0:15] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64,
                          32, 16, 8, 4, 2, 1, 0, 0};

  // Stimulus and scoreboard
  nav_item_t  cmd_backlog [$];
  wheel_cmd_t due_wheels [$];
  nav_item_t  offered;
  int n_queued   = 0;
  int n_accepted = 0;
  int n_fail     = 0;

  // Idling controls, set between phases
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_reqs = 0;
  int hold_done = 0;
  int hold_left = 0;

  // One wrap by 2*pi into [-pi, pi]; serves goal headings and heading errors alike
  function automatic int wrap_pi(int a);
    if (a > ANG_PI) return a - ANG_TWO_PI;
    if (a < -ANG_PI) return a + ANG_TWO_PI;
    return a;
  endfunction

  function automatic int clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // Vectoring CORDIC bearing of (ex, ey); errors pre-scaled by 2^8
  function automatic int cordic_bearing(int ey, int ex);
    longint x, y, z, dx, dy;
    int     steps;
    x = longint'(ex) * 256;
    y = longint'(ey) * 256;
    z = 0;
    steps = (CORDIC_STEPS_DEF > 16) ? 16 : CORDIC_STEPS_DEF;
    if (ex == 0 && ey == 0) return 0;
    // left half-plane: rotate by pi first
    if (x < 0) begin
      z = (y >= 0) ? ANG_PI : -ANG_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_lut[i];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_lut[i];
      end
    end
    if (z > ANG_PI) z = ANG_PI;
    if (z < -ANG_PI) z = -ANG_PI;
    return int'(z);
  endfunction

  // Proportional steering: differential = gain * error + 0.5, truncated toward zero
  function automatic void steer_to(int ph);
    longint e, d, g, base;
    e = wrap_pi(tgt_heading - ph);
    g = steer_gain;
    base = drive_speed;
    d = (g * e + 64'sd1048576) / 64'sd2097152;
    left_held  = clamp16(base - d);
    right_held = clamp16(base + d);
  endfunction

  // Advance the shadow by one transaction and return the wheel command it yields
  function automatic wheel_cmd_t navigate(nav_item_t it);
    wheel_cmd_t w;
    int px, py, ph, ex, ey, e, l1, thr, rs;
    px = it.pose_x;
    py = it.pose_y;
    ph = it.pose_heading;
    rs = rotate_speed;
    case (it.cmd)
      CMD_TICK: begin
        if (nav_mode == MODE_MOVE) begin
          ex = dest_x - px;
          ey = dest_y - py;
          l1 = (ex < 0 ? -ex : ex) + (ey < 0 ? -ey : ey);
          thr = arrive_thresh;
          if (l1 < thr) begin
            left_held = 0;
            right_held = 0;
            nav_mode = MODE_DONE;
          end else begin
            tgt_heading = cordic_bearing(ey, ex);
            steer_to(ph);
          end
        end else if (nav_mode == MODE_GO) begin
          steer_to(ph);
        end else if (nav_mode == MODE_ROT) begin
          e = wrap_pi(tgt_heading - ph);
          thr = head_thresh;
          if ((e < 0 ? -e : e) < thr) begin
            left_held = 0;
            right_held = 0;
            nav_mode = MODE_DONE;
          end else if (e > 0) begin
            left_held = -rs;
            right_held = rs;
          end else begin
            left_held = rs;
            right_held = -rs;
          end
        end
      end
      CMD_MOVE: begin
        dest_x = it.goal_x;
        dest_y = it.goal_y;
        nav_mode = MODE_MOVE;
      end
      CMD_TURN: begin
        tgt_heading = wrap_pi(it.goal_heading);
        nav_mode = MODE_ROT;
      end
      CMD_GO: begin
        tgt_heading = wrap_pi(it.goal_heading);
        nav_mode = MODE_GO;
      end
      CMD_STOP: begin
        left_held = 0;
        right_held = 0;
        nav_mode = MODE_DONE;
      end
      default: ;  // spare codes leave everything as it is
    endcase
    w.left  = SPD_W'(left_held);
    w.right = SPD_W'(right_held);
    w.mode  = nav_mode;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic signed [POS_W-1:0] rnd16();
    return POS_W'($urandom());
  endfunction

  // centre plus an offset whose scale is itself random (1 .. 2^15)
  function automatic logic signed [POS_W-1:0] near(int centre);
    int span, off;
    span = 1 << $urandom_range(15, 0);
    off = int'($urandom_range(2 * span, 0)) - span;
    return POS_W'(centre + off);
  endfunction

  // Mostly in-range headings, now and then any 16-bit value
  function automatic logic signed [ANG_W-1:0] rnd_heading();
    if ($urandom_range(9, 0) == 0) return rnd16();
    return ANG_W'(int'($urandom_range(2 * ANG_PI, 0)) - ANG_PI);
  endfunction

  function automatic nav_item_t rand_item(logic [CMD_W-1:0] cmd);
    nav_item_t it;
    it.cmd          = cmd;
    it.pose_x       = rnd16();
    it.pose_y       = rnd16();
    it.pose_heading = rnd_heading();
    it.goal_x       = rnd16();
    it.goal_y       = rnd16();
    it.goal_heading = rnd16();
    return it;
  endfunction

  task automatic queue_item(nav_item_t it);
    cmd_backlog.push_back(it);
    n_queued++;
  endtask

  task automatic push_cmd(logic [CMD_W-1:0] cmd, int px, int py, int ph,
                          int gx, int gy, int gh);
    nav_item_t it;
    it.cmd          = cmd;
    it.pose_x       = POS_W'(px);
    it.pose_y       = POS_W'(py);
    it.pose_heading = ANG_W'(ph);
    it.goal_x       = POS_W'(gx);
    it.goal_y       = POS_W'(gy);
    it.goal_heading = ANG_W'(gh);
    queue_item(it);
  endtask

  // A command followed by a run of pose ticks that home in on it; the rest is noise
  task automatic add_episode();
    nav_item_t it;
    int kind, n, gx, gy, th;
    kind = $urandom_range(99, 0);
    n = $urandom_range(8, 2);
    if (kind < 40) begin
      it = rand_item(CMD_MOVE);
      if ($urandom_range(1, 0) == 1) begin
        it.goal_x = POS_W'(int'($urandom_range(2000, 0)) - 1000);
        it.goal_y = POS_W'(int'($urandom_range(2000, 0)) - 1000);
      end
      queue_item(it);
      gx = it.goal_x;
      gy = it.goal_y;
      repeat (n) begin
        it = rand_item(CMD_TICK);
        it.pose_x = near(gx);
        it.pose_y = near(gy);
        queue_item(it);
      end
    end else if (kind < 60) begin
      queue_item(rand_item(CMD_GO));
      repeat (n) queue_item(rand_item(CMD_TICK));
    end else if (kind < 80) begin
      it = rand_item(CMD_TURN);
      queue_item(it);
      th = wrap_pi(it.goal_heading);
      repeat (n) begin
        it = rand_item(CMD_TICK);
        it.pose_heading = near(th);
        queue_item(it);
      end
    end else begin
      // stray commands of any code, ticks, stops and spare codes included
      repeat ($urandom_range(3, 1)) queue_item(rand_item(CMD_W'($urandom_range(7, 0))));
    end
  endtask

  // Register write: one per cycle, write enable dropped by the caller's sequence
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    case (idx)
      CFG_DRIVE_SPEED:   drive_speed   = 15'(val);
      CFG_ROTATE_SPEED:  rotate_speed  = 15'(val);
      CFG_STEER_GAIN:    steer_gain    = 16'(val);
      CFG_ARRIVE_THRESH: arrive_thresh = 16'(val);
      CFG_HEAD_THRESH:   head_thresh   = 15'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(int ds, int rs, int sg, int at, int ht);
    write_reg(CFG_DRIVE_SPEED, ds);
    write_reg(CFG_ROTATE_SPEED, rs);
    write_reg(CFG_STEER_GAIN, sg);
    write_reg(CFG_ARRIVE_THRESH, at);
    write_reg(CFG_HEAD_THRESH, ht);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued transaction is in and every wheel command is out
  task automatic settle();
    do @(posedge clk);
    while (n_accepted != n_queued || due_wheels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int send_pct, int stall_pct, int upto, bit long_hold);
    @(negedge clk);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    // backlog is filled in one go, so the sender keeps offering through the hold-off
    if (long_hold) hold_reqs++;
    while (n_queued < upto) add_episode();
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offers the backlog on in_ch, predicting each transaction as it is taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        due_wheels.push_back(navigate(offered));
        n_accepted++;
      end
      if (cmd_backlog.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        offered = cmd_backlog.pop_front();
        in_ch.cmd          <= offered.cmd;
        in_ch.pose_x       <= offered.pose_x;
        in_ch.pose_y       <= offered.pose_y;
        in_ch.pose_heading <= offered.pose_heading;
        in_ch.goal_x       <= offered.goal_x;
        in_ch.goal_y       <= offered.goal_y;
        in_ch.goal_heading <= offered.goal_heading;
        in_ch.valid        <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each out_ch transaction against the oldest prediction and
  // drives ready, including the long hold-off that backs the block up
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    wheel_cmd_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_wheels.size() == 0) begin
          $error("unexpected wheel command: left %0d right %0d mode %0d",
                 out_ch.left_speed, out_ch.right_speed, out_ch.mode_now);
          n_fail++;
        end else begin
          want = due_wheels.pop_front();
          if (out_ch.left_speed !== want.left) begin
            $error("left_speed: expected %0d, got %0d", want.left, out_ch.left_speed);
            n_fail++;
          end
          if (out_ch.right_speed !== want.right) begin
            $error("right_speed: expected %0d, got %0d", want.right, out_ch.right_speed);
            n_fail++;
          end
          if (out_ch.mode_now !== want.mode) begin
            $error("mode_now: expected %0d, got %0d", want.mode, out_ch.mode_now);
            n_fail++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_done != hold_reqs) begin
        hold_done++;
        hold_left = LONG_HOLD;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: too long with no transaction on either channel means a hang
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed corner cases, then four random phases
  // ---------------------------------------------------------------------------
  initial begin
    // every block input known from time zero
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_DRIVE_SPEED;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.cmd          = CMD_TICK;
    in_ch.pose_x       = '0;
    in_ch.pose_y       = '0;
    in_ch.pose_heading = '0;
    in_ch.goal_x       = '0;
    in_ch.goal_y       = '0;
    in_ch.goal_heading = '0;
    out_ch.ready       = 1'b0;

    // shadow matches the block's reset
    drive_speed   = '0;
    rotate_speed  = '0;
    steer_gain    = '0;
    arrive_thresh = '0;
    head_thresh   = '0;
    nav_mode      = MODE_DONE;
    dest_x        = 0;
    dest_y        = 0;
    tgt_heading   = 0;
    left_held     = 0;
    right_held    = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: full speeds and gain so steering saturates; no arrival, so the
    // zero-length error vector still reaches the bearing
    set_config(32767, 32767, 65535, 0, 200);
    @(negedge clk);
    push_cmd(CMD_TICK, 32767, -32768, ANG_PI, 0, 0, 0);         // tick while done
    push_cmd(CMD_W'(5), -32768, 32767, -ANG_PI, 32767, -32768, 32767);   // spare codes
    push_cmd(CMD_W'(6), 0, 0, 0, -32768, 32767, -32768);
    push_cmd(CMD_W'(7), -1, -1, -1, -1, -1, -1);
    push_cmd(CMD_MOVE, 0, 0, 0, 0, 0, 0);
    push_cmd(CMD_TICK, 0, 0, -ANG_PI, 0, 0, 0);                 // zero error vector
    push_cmd(CMD_TICK, 100, -5, 0, 0, 0, 0);                    // x < 0, y >= 0: start +pi
    push_cmd(CMD_TICK, 100, 5, 0, 0, 0, 0);                     // x < 0, y < 0: start -pi
    push_cmd(CMD_TURN, 0, 0, 0, 0, 0, 32767);                   // command holds speeds
    push_cmd(CMD_MOVE, 0, 0, 0, 32767, -32768, 0);
    push_cmd(CMD_TICK, -32768, 32767, -ANG_PI, 0, 0, 0);        // largest errors
    push_cmd(CMD_TICK, -32768, -32768, ANG_PI, 0, 0, 0);
    push_cmd(CMD_GO, 0, 0, 0, 0, 0, -32768);                    // goal wrapped up by 2*pi
    push_cmd(CMD_TICK, 0, 0, -ANG_PI, 0, 0, 0);                 // left side saturates
    push_cmd(CMD_TICK, 0, 0, 32767, 0, 0, 0);                   // pose heading past pi
    push_cmd(CMD_STOP, 0, 0, 0, 0, 0, 0);
    push_cmd(CMD_TURN, 0, 0, 0, 0, 0, 32767);
    push_cmd(CMD_TICK, 0, 0, 0, 0, 0, 0);                       // spin one way
    push_cmd(CMD_TICK, 0, 0, -32768, 0, 0, 0);                  // and the other
    push_cmd(CMD_TICK, 0, 0, -18600, 0, 0, 0);                  // within threshold: done
    push_cmd(CMD_TURN, 0, 0, 0, 0, 0, -32768);
    push_cmd(CMD_TICK, 0, 0, -32768, 0, 0, 0);                  // error wraps to zero
    push_cmd(CMD_GO, 0, 0, 0, 0, 0, ANG_PI);
    push_cmd(CMD_TICK, 0, 0, -ANG_PI, 0, 0, 0);
    push_cmd(CMD_STOP, 0, 0, 0, 0, 0, 0);
    settle();

    // Moderate settings, no idling, one long receiver hold-off to fill the block
    set_config(1200, 900, 4096, 300, 400);
    run_phase(0, 0, 200, 1'b1);

    // Top of every register range but the heading threshold (pi), sparse sender
    set_config(32767, 32767, 65535, 65535, ANG_PI);
    run_phase(87, 0, 380, 1'b0);

    // Everything at zero: no arrival, no rotation end, zero speeds; slow receiver
    set_config(0, 0, 0, 0, 0);
    run_phase(0, 87, 560, 1'b0);

    // Random settings, both sides idling now and then
    set_config($urandom_range(32767, 0), $urandom_range(32767, 0),
               $urandom_range(65535, 0), $urandom_range(65535, 0),
               $urandom_range(ANG_PI, 0));
    run_phase(31, 31, 770, 1'b0);

    if (n_fail == 0 && due_wheels.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
